>>> rtl/core/swks_pkg.sv
// Shared types and constants for the 2D sliding-window rank filter.
// Used by swks_ctrl, swks_dp and the top level; no dependencies.
package swks_pkg;

  localparam int MaxWidth      = 1024;
  localparam int MaxWindowRows = 16;
  localparam int MaxWindowCols = 16;
  localparam int MaxRank       = 16;
  localparam int PixelBits     = 16;

  localparam int ColBits  = $clog2(MaxWidth);       // column address
  localparam int SlotBits = $clog2(MaxWindowRows);  // line slot address
  localparam int AddrBits = ColBits + SlotBits;
  localparam int BitIdxW  = $clog2(PixelBits);
  localparam int CntBits  = $clog2(MaxWindowRows * MaxWindowCols + 1);

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_WINDOW_HEIGHT = 2'd1,
    REG_WINDOW_WIDTH  = 2'd2,
    REG_RANK          = 2'd3
  } cfg_idx_t;

  // Controller states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CHECK = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_PASS  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;   // item accepted this cycle
    logic init;   // start a selection
    logic issue;  // read the next window pixel
    logic pass;   // close one bit pass
    logic emit;   // move result to the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit_pending;  // accepted item yields a result
    logic rank_over;     // rank exceeds window size
    logic scan_last;     // last window pixel being read
    logic bit_zero;      // current pass is the lowest bit
    logic out_free;      // output register can take a result
  } status_t;

endpackage

>>> rtl/core/sliding_window_kth_smallest_2d.sv
// Each accepted pixel yielding a result runs 16 bit passes, each reading the window
// from one memory port, then its result moves to the output register (directly when rank
// exceeds n = window_height*window_width); output stalls delay it. A new pixel is taken
// only when the controller is idle again. Reset (rst_n, synchronous, active low) clears
// control, position counters and valid flags and loads the configuration defaults;
// the line memory needs no clearing. Depends on swks_pkg, swks_ctrl, swks_dp.
module sliding_window_kth_smallest_2d import swks_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_addr,
  input  logic [10:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] pixel
  input  logic        in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] kth_value
  output logic        out_tlast   // last_in_row
);

  cmd_t    cmd;
  status_t status;

  swks_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  swks_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_addr    (cfg_addr),
    .cfg_wr_data (cfg_wr_data),
    .pixel       (in_tdata),
    .frame_start (in_tuser),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_value   (out_tdata),
    .out_last    (out_tlast)
  );

endmodule

>>> rtl/core/swks_ctrl.sv
// Sequencer for the rank filter: accept, per-bit scan passes, output.
// Depends on swks_pkg.
module swks_ctrl import swks_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state_r, state_nxt;

  // No item is taken while reset is held
  assign in_ready = rst_n && (state_r == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.init = 1'b1;
        if (!status.emit_pending) state_nxt = ST_IDLE;
        else if (status.rank_over) state_nxt = ST_OUT;
        else state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (status.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_PASS;
      ST_PASS: begin
        cmd.pass  = 1'b1;
        state_nxt = status.bit_zero ? ST_OUT : ST_SCAN;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

endmodule

>>> rtl/core/swks_dp.sv
// Datapath: config registers, line memory, counters, radix selection.
// Depends on swks_pkg.
module swks_dp import swks_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [1:0]           cfg_addr,
  input  logic [10:0]          cfg_wr_data,
  input  logic [PixelBits-1:0] pixel,
  input  logic                 frame_start,
  input  cmd_t                 cmd,
  output status_t              status,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PixelBits-1:0] out_value,
  output logic                 out_last
);

  logic [10:0] iw_cfg_r;
  logic [4:0]  wh_cfg_r, ww_cfg_r, rank_cfg_r;
  logic [10:0] iw_eff;
  logic [4:0]  wh_eff, ww_eff, k_eff;
  logic [CntBits-1:0] n_win;

  logic [ColBits-1:0]  col_cnt_r, cur_col_r;
  logic [4:0]          row_cnt_r;
  logic [SlotBits-1:0] head_r, cur_head_r;
  logic                cur_last_r, emit_r;

  logic [ColBits-1:0]  col_now;
  logic [4:0]          row_now;
  logic                last_now, emit_now;

  logic [SlotBits-1:0] c_r, r_r;
  logic [AddrBits-1:0] rd_addr;
  logic [PixelBits-1:0] mem [MaxWidth*MaxWindowRows];
  logic [PixelBits-1:0] rd_data_r;
  logic                 rd_vld_r;

  logic [BitIdxW-1:0]   bit_r;
  logic [PixelBits-1:0] res_r;
  logic [4:0]           rem_r;
  logic [CntBits-1:0]   cnt_r;

  logic [PixelBits-1:0] out_value_r;
  logic                 out_last_r, out_valid_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iw_cfg_r   <= 11'd1024;
      wh_cfg_r   <= 5'd3;
      ww_cfg_r   <= 5'd3;
      rank_cfg_r <= 5'd5;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_addr))
        REG_IMAGE_WIDTH:   iw_cfg_r   <= cfg_wr_data;
        REG_WINDOW_HEIGHT: wh_cfg_r   <= cfg_wr_data[4:0];
        REG_WINDOW_WIDTH:  ww_cfg_r   <= cfg_wr_data[4:0];
        REG_RANK:          rank_cfg_r <= cfg_wr_data[4:0];
        default: ;
      endcase
    end
  end

  // Zero acts as one, above range saturates
  always_comb begin
    iw_eff = (iw_cfg_r == '0) ? 11'd1 :
             (iw_cfg_r > 11'(MaxWidth)) ? 11'(MaxWidth) : iw_cfg_r;
    wh_eff = (wh_cfg_r == '0) ? 5'd1 :
             (wh_cfg_r > 5'(MaxWindowRows)) ? 5'(MaxWindowRows) : wh_cfg_r;
    ww_eff = (ww_cfg_r == '0) ? 5'd1 :
             (ww_cfg_r > 5'(MaxWindowCols)) ? 5'(MaxWindowCols) : ww_cfg_r;
    k_eff  = (rank_cfg_r == '0) ? 5'd1 :
             (rank_cfg_r > 5'(MaxRank)) ? 5'(MaxRank) : rank_cfg_r;
    n_win  = CntBits'(wh_eff) * CntBits'(ww_eff);
  end

  // Position of the arriving pixel
  always_comb begin
    col_now  = frame_start ? '0 : col_cnt_r;
    row_now  = frame_start ? '0 : row_cnt_r;
    last_now = ({1'b0, col_now} + 11'd1) >= iw_eff;
    emit_now = ({1'b0, row_now} + 6'd1 >= {1'b0, wh_eff}) &&
               ({1'b0, col_now} + 11'd1 >= {6'd0, ww_eff});
  end

  // Row and column tracking; head is the line slot of the current row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
      head_r    <= '0;
      emit_r    <= 1'b0;
    end else if (cmd.load) begin
      emit_r <= emit_now;
      if (last_now) begin
        col_cnt_r <= '0;
        head_r    <= head_r + 1'b1;
        if (row_now < 5'd31) row_cnt_r <= row_now + 5'd1;
        else                 row_cnt_r <= row_now;
      end else begin
        col_cnt_r <= col_now + 1'b1;
        row_cnt_r <= row_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_col_r  <= col_now;
      cur_head_r <= head_r;
      cur_last_r <= last_now;
    end
  end

  // Line memory: column by slot, one write and one read port
  assign rd_addr = {cur_col_r - ColBits'(c_r), cur_head_r - r_r};

  always_ff @(posedge clk) begin
    if (cmd.load) mem[{col_now, head_r}] <= pixel;
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rd_vld_r <= 1'b0;
    else        rd_vld_r <= cmd.issue;
  end

  // Window walk: rows inside columns
  assign status.scan_last = ({1'b0, c_r} == ww_eff - 5'd1) &&
                            ({1'b0, r_r} == wh_eff - 5'd1);

  always_ff @(posedge clk) begin
    if (cmd.init || cmd.pass) begin
      c_r <= '0;
      r_r <= '0;
    end else if (cmd.issue) begin
      if ({1'b0, r_r} == wh_eff - 5'd1) begin
        r_r <= '0;
        c_r <= c_r + 1'b1;
      end else begin
        r_r <= r_r + 1'b1;
      end
    end
  end

  // Radix selection, one bit per pass from the top
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      bit_r <= BitIdxW'(PixelBits - 1);
      res_r <= (k_eff > {1'b0, n_win[3:0]} && n_win < CntBits'(16)) ||
               (CntBits'(k_eff) > n_win) ? '1 : '0;
      rem_r <= k_eff;
      cnt_r <= '0;
    end else if (cmd.pass) begin
      if ({{(CntBits-5){1'b0}}, rem_r} > cnt_r) begin
        rem_r <= rem_r - cnt_r[4:0];
        res_r <= res_r | (PixelBits'(1) << bit_r);
      end
      bit_r <= bit_r - 1'b1;
      cnt_r <= '0;
    end else if (rd_vld_r && (((rd_data_r ^ res_r) >> bit_r) == '0)) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.emit) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_value_r <= res_r;
      out_last_r  <= cur_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

  assign status.emit_pending = emit_r;
  assign status.rank_over    = CntBits'(k_eff) > n_win;
  assign status.bit_zero     = (bit_r == '0);
  assign status.out_free     = !out_valid_r || out_ready;

endmodule

>>> test/tb.sv
// Testbench for sliding_window_kth_smallest_2d: streams raster images with frame marks,
// predicts each rank-filter result in the bench and compares it with the block output.
// Depends on swks_pkg and the RTL of the block.
module tb;
  import swks_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [10:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] pixel
  logic        in_tuser = 1'b0; // [0] frame_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [15:0] kth_value
  logic        out_tlast;       // last_in_row

  sliding_window_kth_smallest_2d dut (.*);

  always #5 clk = ~clk;

  typedef struct packed {
    logic [15:0] kth_value;
    logic        last_in_row;
  } filt_res_t;

  // bench copy of block state and registers
  logic [15:0] line_mem [MaxWidth][MaxWindowRows];
  logic [15:0] win_vals [MaxWindowRows*MaxWindowCols];
  int unsigned rows_done, col_next;
  int unsigned reg_iw, reg_wh, reg_ww, reg_rank;
  filt_res_t   pending_q[$];
  int          errors = 0;
  bit          quiet = 1'b0;   // disables idling for a stretch

  function automatic int unsigned sat_reg(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // bit-serial selection of the k-th smallest of n gathered pixels
  function automatic logic [15:0] kth_of(int unsigned n, int unsigned k);
    logic [15:0] acc;
    int unsigned left, cnt;
    logic [15:0] hmask;
    acc = '0;
    left = k;
    for (int b = 15; b >= 0; b--) begin
      hmask = 16'hFFFF << (b + 1);
      if (b == 15) hmask = '0;
      cnt = 0;
      for (int i = 0; i < n; i++)
        if (((win_vals[i] & hmask) == acc) && !win_vals[i][b]) cnt++;
      if (left > cnt) begin
        left -= cnt;
        acc[b] = 1'b1;
      end
    end
    return acc;
  endfunction

  // advance the bench state by one pixel and queue any result
  task automatic predict_pixel(logic [15:0] px, logic fs);
    int unsigned iw, wh, ww, k, c, n, i;
    bit last;
    filt_res_t r;
    iw = sat_reg(reg_iw, MaxWidth);
    wh = sat_reg(reg_wh, MaxWindowRows);
    ww = sat_reg(reg_ww, MaxWindowCols);
    k = sat_reg(reg_rank, MaxRank);
    if (fs) begin
      rows_done = 0;
      col_next = 0;
    end
    c = col_next;
    last = (c + 1 >= iw);
    if (c >= MaxWidth) c = MaxWidth - 1;
    for (int s = MaxWindowRows - 1; s > 0; s--) line_mem[c][s] = line_mem[c][s-1];
    line_mem[c][0] = px;
    if (rows_done + 1 >= wh && c + 1 >= ww) begin
      n = wh * ww;
      i = 0;
      for (int cc = 0; cc < ww; cc++)
        for (int rr = 0; rr < wh; rr++) win_vals[i++] = line_mem[c-cc][rr];
      r.kth_value = (k > n) ? 16'hFFFF : kth_of(n, k);
      r.last_in_row = last;
      pending_q.push_back(r);
    end
    if (last) begin
      col_next = 0;
      if (rows_done < 31) rows_done++;
    end else col_next = (c + 1) & 10'h3FF;
  endtask

  // send one pixel, with random idle cycles beforehand; valid stays up after
  // the accept until the next pixel or a register write replaces it
  task automatic send_pixel(logic [15:0] px, logic fs);
    while (!quiet && $urandom_range(99) < 6) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= px;
    in_tuser <= fs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_pixel(px, fs);
  endtask

  // register write while the block is idle
  task automatic write_reg(cfg_idx_t idx, logic [10:0] val);
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:   reg_iw = val;
      REG_WINDOW_HEIGHT: reg_wh = val & 5'h1F;
      REG_WINDOW_WIDTH:  reg_ww = val & 5'h1F;
      default:           reg_rank = val & 5'h1F;
    endcase
  endtask

  task automatic set_regs(int iw, int wh, int ww, int rk);
    write_reg(REG_IMAGE_WIDTH, 11'(iw));
    write_reg(REG_WINDOW_HEIGHT, 11'(wh));
    write_reg(REG_WINDOW_WIDTH, 11'(ww));
    write_reg(REG_RANK, 11'(rk));
  endtask

  // full frame; pixel chosen by mode: 0 random, 1 extremes, 2 random low bits
  task automatic send_frame(int rows, int mode);
    int unsigned w;
    logic [15:0] px;
    w = sat_reg(reg_iw, MaxWidth);
    for (int y = 0; y < rows; y++)
      for (int x = 0; x < w; x++) begin
        case (mode)
          1:       px = $urandom_range(1) ? 16'hFFFF : 16'h0000;
          2:       px = 16'($urandom_range(7));
          default: px = 16'($urandom);
        endcase
        send_pixel(px, (x == 0 && y == 0));
      end
  endtask

  // result checker with random stalls
  always @(posedge clk) begin
    filt_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result kth=%h last=%b", $time, out_tdata, out_tlast);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_tdata !== e.kth_value) begin
          $display("%0t: kth_value expected %h actual %h", $time, e.kth_value, out_tdata);
          errors++;
        end
        if (out_tlast !== e.last_in_row) begin
          $display("%0t: last_in_row expected %b actual %b", $time, e.last_in_row, out_tlast);
          errors++;
        end
      end
    end
    out_tready <= quiet || ($urandom_range(99) >= 6);
  end

  // small images with the reset window and rank, then extremes of window and rank
  task automatic test_directed();
    set_regs(4, 3, 3, 5);
    send_frame(3, 1);
    // rank above window size, rank zero, registers at zero
    set_regs(3, 1, 2, 16);
    send_frame(2, 0);
    set_regs(0, 0, 0, 0);
    send_frame(3, 0);
    // window wider than the row gives nothing
    set_regs(2, 1, 5, 1);
    send_frame(2, 0);
  endtask

  // mid-row width drop: the pixel ends its row
  task automatic test_width_drop();
    set_regs(6, 1, 1, 1);
    for (int x = 0; x < 4; x++) send_pixel(16'($urandom), x == 0);
    write_reg(REG_IMAGE_WIDTH, 11'd2);
    send_pixel(16'h8001, 1'b0);
    send_pixel(16'h7FFE, 1'b0);
    // oversized width saturates: a short run stays inside the row
    set_regs(11'h7FF, 1, 1, 1);
    for (int x = 0; x < 8; x++) send_pixel(16'($urandom), x == 0);
    // oversized window and rank saturate to the largest window
    set_regs(16, 31, 31, 31);
    send_frame(16, 2);
  endtask

  // random frames with varied settings
  task automatic test_random();
    int sent;
    int w, rows;
    sent = 0;
    while (sent < 1250) begin
      w = $urandom_range(1, 12);
      if ($urandom_range(9) == 0) w = $urandom_range(13, 40);
      rows = $urandom_range(1, 6);
      quiet = (sent > 600 && sent < 900);
      set_regs(w, $urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(0, 17));
      send_frame(rows, $urandom_range(2));
      sent += w * rows;
    end
    quiet = 1'b0;
  endtask

  initial begin
    reg_iw = 1024; reg_wh = 3; reg_ww = 3; reg_rank = 5;
    rows_done = 0; col_next = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_width_drop();
    test_random();
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end
endmodule
